FILE: design/ce_pkg.sv
// Shared types and constants for the composition enumerator.
// No dependencies; used by ce_ctrl, ce_dp and composition_enumerator.
package ce_pkg;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int PCOUNT_W   = 4;
  localparam int TOTAL_W    = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL      = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 4'd2;
  localparam logic [TOTAL_W-1:0]  TOTAL_RST  = 8'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic emit;     // write the output register
    logic load;     // load the first split
    logic advance;  // commit the next split
    logic more;     // more flag of the emitted beat
  } ce_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a beat this cycle
    logic adv_ok;    // a next split exists
  } ce_stat_t;

endpackage

FILE: design/composition_enumerator.sv
// Top level of the composition enumerator: joins controller and datapath.
// Depends on ce_pkg, ce_ctrl and ce_dp.
//
// Steps through every weak composition of total into part_count parts.
// Input channel (in_valid/in_ready/in_restart): restart 1 loads the first
// split, with the whole total in part 0; restart 0 moves to the next split.
// Output channel (out_valid/out_ready): one beat per input beat, carrying
// the packed parts (part 0 in the low bits) and more, which is 0 with all
// parts zero once the sequence is used up.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready; index 0 is part_count, index 1 is total. Write it only while idle.
// The controller holds the taken input beat, and the result is written to the
// output register as soon as that register is free (out_free).
// The controller holds one item at a time and drops its registered ready
// while it works on it; the next input beat is taken once that item is emitted.
// When the receiver stalls, the result waits in the output register and the
// next input beat is still taken; that item then waits until the register
// frees up. Reset sets part_count to 2 and total to 0, clears the parts, and
// the first advance after reset reports the held split with more set.
module composition_enumerator #(
  parameter int MAX_PARTS = 8,
  parameter int PART_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [MAX_PARTS*PART_BITS-1:0] out_parts,
  output logic                           out_more,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ce_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ce_pkg::ce_cmd_t  cmd;
  ce_pkg::ce_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencing and handshake.
  ce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Parts, next-split logic and output register.
  ce_dp #(
    .MAX_PARTS (MAX_PARTS),
    .PART_BITS (PART_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_parts (out_parts),
    .out_more  (out_more)
  );

`ifndef SYNTH
  // An exhausted beat carries no parts.
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_more) |-> (out_parts == '0))
    else $error("exhausted beat with nonzero parts");

  // Only one item is held at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is held");

  // A restart with a free output register leads to a valid split with more set.
  a_restart_more: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_restart && (!out_valid || out_ready))
      |=> ##1 (out_valid && out_more))
    else $error("restart did not report the first split");
`endif

endmodule

FILE: design/ce_ctrl.sv
// Controller of the composition enumerator: input handshake and sequence flags.
// Depends on ce_pkg for the command and status structs.
module ce_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_restart,
  input  ce_pkg::ce_stat_t stat,
  output ce_pkg::ce_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   restart_r;
  logic   first_pending_r;
  logic   exhausted_r;

  assign in_ready = in_ready_r;

  // Decide what the held item does once the output register is free.
  always_comb begin
    cmd = '0;
    if (state_r == S_WORK && stat.out_free) begin
      cmd.emit = 1'b1;
      priority if (restart_r) begin
        cmd.load = 1'b1;
        cmd.more = 1'b1;
      end else if (first_pending_r) begin
        cmd.more = 1'b1;
      end else if (exhausted_r) begin
        cmd.more = 1'b0;
      end else begin
        cmd.advance = stat.adv_ok;
        cmd.more    = stat.adv_ok;
      end
    end
  end

  // State, sequence flags and the registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      in_ready_r      <= 1'b1;
      first_pending_r <= 1'b1;
      exhausted_r     <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready_r) begin
            restart_r  <= in_restart;
            state_r    <= S_WORK;
            in_ready_r <= 1'b0;
          end
        end
        S_WORK: begin
          if (stat.out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
            priority if (restart_r) begin
              first_pending_r <= 1'b0;
              exhausted_r     <= 1'b0;
            end else if (first_pending_r) begin
              first_pending_r <= 1'b0;
            end else if (!exhausted_r && !stat.adv_ok) begin
              exhausted_r <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/ce_dp.sv
// Datapath of the composition enumerator: configuration, part registers,
// next-split logic and the output register. Depends on ce_pkg.
module ce_dp #(
  parameter int MAX_PARTS = 8,
  parameter int PART_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [ce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ce_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  ce_pkg::ce_cmd_t                  cmd,
  output ce_pkg::ce_stat_t                 stat,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [MAX_PARTS*PART_BITS-1:0]   out_parts,
  output logic                             out_more
);

  localparam logic [ce_pkg::TOTAL_W-1:0]  PART_MAX_W =
    ce_pkg::TOTAL_W'((1 << PART_BITS) - 1);
  localparam logic [ce_pkg::PCOUNT_W-1:0] MAX_PARTS_W = ce_pkg::PCOUNT_W'(MAX_PARTS);

  logic [ce_pkg::PCOUNT_W-1:0] part_count_r;
  logic [ce_pkg::TOTAL_W-1:0]  total_r;
  logic [PART_BITS-1:0]        part_r [MAX_PARTS];
  logic [PART_BITS-1:0]        part_nxt [MAX_PARTS];
  logic [PART_BITS-1:0]        adv_part [MAX_PARTS];
  logic                        out_valid_r;
  logic [MAX_PARTS*PART_BITS-1:0] out_parts_r;
  logic [MAX_PARTS*PART_BITS-1:0] pack_nxt;
  logic                        out_more_r;

  logic [ce_pkg::PCOUNT_W-1:0] act_n;
  logic [PART_BITS-1:0]        total_sat;
  logic                        p0_nz;
  logic                        found;
  logic [ce_pkg::PCOUNT_W-1:0] fi;
  logic [PART_BITS-1:0]        sel_val;

  // Saturated part count and total.
  assign act_n     = (part_count_r > MAX_PARTS_W) ? MAX_PARTS_W : part_count_r;
  assign total_sat = (total_r > PART_MAX_W) ? '1 : total_r[PART_BITS-1:0];
  assign p0_nz     = (part_r[0] != '0);

  // Priority search for the first nonzero part above part 0.
  always_comb begin
    found   = 1'b0;
    fi      = '0;
    sel_val = '0;
    for (int i = 1; i < MAX_PARTS; i++) begin
      if (!found && (ce_pkg::PCOUNT_W'(i) < act_n) && (part_r[i] != '0)) begin
        found   = 1'b1;
        fi      = ce_pkg::PCOUNT_W'(i);
        sel_val = part_r[i];
      end
    end
  end

  assign stat.adv_ok   = (act_n > ce_pkg::PCOUNT_W'(1)) &&
                         (p0_nz || (found && (fi != act_n - ce_pkg::PCOUNT_W'(1))));
  assign stat.out_free = !out_valid_r || out_ready;

  // Next split, built lane by lane.
  always_comb begin
    for (int j = 0; j < MAX_PARTS; j++) begin
      adv_part[j] = part_r[j];
      if (p0_nz) begin
        if (j == 0) begin
          adv_part[j] = part_r[j] - PART_BITS'(1);
        end else if (j == 1) begin
          adv_part[j] = part_r[j] + PART_BITS'(1);
        end
      end else begin
        if (j == 0) begin
          adv_part[j] = sel_val - PART_BITS'(1);
        end else if (ce_pkg::PCOUNT_W'(j) == fi) begin
          adv_part[j] = '0;
        end else if (ce_pkg::PCOUNT_W'(j) == fi + ce_pkg::PCOUNT_W'(1)) begin
          adv_part[j] = part_r[j] + PART_BITS'(1);
        end
      end
    end
  end

  // Select what the parts become, and pack the active ones for output.
  always_comb begin
    pack_nxt = '0;
    for (int j = 0; j < MAX_PARTS; j++) begin
      priority if (cmd.load) begin
        part_nxt[j] = (j == 0 && act_n != '0) ? total_sat : '0;
      end else if (cmd.advance) begin
        part_nxt[j] = adv_part[j];
      end else begin
        part_nxt[j] = part_r[j];
      end
      if (ce_pkg::PCOUNT_W'(j) < act_n) begin
        pack_nxt[j*PART_BITS +: PART_BITS] = part_nxt[j];
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r <= ce_pkg::PCOUNT_RST;
      total_r      <= ce_pkg::TOTAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ce_pkg::REG_PART_COUNT: part_count_r <= cfg_data[ce_pkg::PCOUNT_W-1:0];
        ce_pkg::REG_TOTAL:      total_r      <= cfg_data[ce_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Part registers; after reset the first split of a zero total is all zeros.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_PARTS; j++) begin
      if (!rst_n) begin
        part_r[j] <= '0;
      end else begin
        part_r[j] <= part_nxt[j];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
      out_parts_r <= cmd.more ? pack_nxt : '0;
      out_more_r  <= cmd.more;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_parts = out_parts_r;
  assign out_more  = out_more_r;

endmodule

FILE: test/ce_checker.sv
`timescale 1ns / 1ps
// Checker for the composition enumerator: tracks the splits the block should produce.
// Depends on ce_pkg. It watches all three channels and counts mismatches.
module ce_checker #(
  parameter int MAX_PARTS = 8,
  parameter int PART_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_restart,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [MAX_PARTS*PART_BITS-1:0] out_parts,
  input  logic                           out_more,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ce_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                    pending,
  output int unsigned                    fail_count
);
  import ce_pkg::*;

  localparam int WORD_W   = MAX_PARTS * PART_BITS;
  localparam int PART_MAX = (1 << PART_BITS) - 1;

  typedef struct packed {
    logic [WORD_W-1:0] parts;
    logic              more;
  } split_t;

  // Shadow copy of the registers and of the enumeration state.
  logic [PCOUNT_W-1:0]  part_count;
  logic [TOTAL_W-1:0]   total;
  logic [PART_BITS-1:0] part_val [MAX_PARTS];
  logic                 first_pend;
  logic                 used_up;
  split_t               split_q [$];

  // Part counts above the array size saturate.
  function automatic int active_parts();
    return (part_count > MAX_PARTS) ? MAX_PARTS : int'(part_count);
  endfunction

  // The first split puts the whole (saturated) total into part 0.
  function automatic void load_first_split();
    for (int i = 0; i < MAX_PARTS; i++) part_val[i] = '0;
    if (active_parts() > 0) begin
      part_val[0] = (total > PART_MAX) ? PART_BITS'(PART_MAX) : PART_BITS'(total);
    end
  endfunction

  // Moves to the next composition in place; returns 0 when none is left.
  function automatic logic step_split();
    int n;
    n = active_parts();
    if (n <= 1) return 1'b0;
    if (part_val[0] != 0) begin
      part_val[0] = part_val[0] - 1'b1;
      part_val[1] = part_val[1] + 1'b1;
      return 1'b1;
    end
    for (int i = 1; i < n; i++) begin
      if (part_val[i] != 0) begin
        if (i == n - 1) return 1'b0;
        part_val[0]     = part_val[i] - 1'b1;
        part_val[i]     = '0;
        part_val[i + 1] = part_val[i + 1] + 1'b1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Only parts below the current count are reported.
  function automatic logic [WORD_W-1:0] packed_parts();
    logic [WORD_W-1:0] word;
    word = '0;
    for (int i = 0; i < active_parts(); i++) word[i*PART_BITS +: PART_BITS] = part_val[i];
    return word;
  endfunction

  // Works out the result beat caused by one input beat.
  function automatic split_t next_split(input logic restart);
    split_t res;
    logic   ok;
    if (restart) begin
      load_first_split();
      first_pend = 1'b0;
      used_up    = 1'b0;
      ok         = 1'b1;
    end else if (first_pend) begin
      first_pend = 1'b0;
      ok         = 1'b1;
    end else if (used_up) begin
      ok = 1'b0;
    end else begin
      ok = step_split();
      if (!ok) used_up = 1'b1;
    end
    res.parts = ok ? packed_parts() : '0;
    res.more  = ok;
    return res;
  endfunction

  // Results are compared before the same edge's input beat is predicted,
  // so a stray result can never match an expectation pushed at that edge.
  always @(posedge clk) begin
    split_t want;
    if (!rst_n) begin
      part_count = PCOUNT_RST;
      total      = TOTAL_RST;
      load_first_split();
      first_pend = 1'b1;
      used_up    = 1'b0;
      split_q.delete();
      fail_count = 0;
      pending   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (split_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected: parts %h more %b",
                   $time, out_parts, out_more);
        end else begin
          want = split_q.pop_front();
          if (out_parts !== want.parts) begin
            fail_count++;
            $display("%0t: parts mismatch: expected %h, actual %h",
                     $time, want.parts, out_parts);
          end
          if (out_more !== want.more) begin
            fail_count++;
            $display("%0t: more mismatch: expected %b, actual %b",
                     $time, want.more, out_more);
          end
        end
      end
      if (in_valid && in_ready) split_q.push_back(next_split(in_restart));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PART_COUNT: part_count = cfg_data[PCOUNT_W-1:0];
          REG_TOTAL:      total = cfg_data[TOTAL_W-1:0];
          default: ;
        endcase
      end
      pending <= split_q.size();
    end
  end

endmodule

FILE: test/tb_composition_enumerator.sv
`timescale 1ns / 1ps
// Top of the composition enumerator testbench: clock, reset, stimulus and verdict.
// Depends on ce_pkg, composition_enumerator and ce_checker.
module tb_composition_enumerator;
  import ce_pkg::*;

  localparam int MAX_PARTS    = 8;
  localparam int PART_BITS    = 8;
  localparam int RANDOM_ITEMS = 900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_restart;
  logic                           out_valid;
  logic                           out_ready;
  logic [MAX_PARTS*PART_BITS-1:0] out_parts;
  logic                           out_more;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [CFG_DATA_W-1:0]          cfg_data;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_cnt = 0;
  logic        long_hold_req;
  logic        burst;

  composition_enumerator #(
    .MAX_PARTS(MAX_PARTS),
    .PART_BITS(PART_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_restart(in_restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_parts (out_parts),
    .out_more  (out_more),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ce_checker #(
    .MAX_PARTS(MAX_PARTS),
    .PART_BITS(PART_BITS)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_restart(in_restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_parts (out_parts),
    .out_more  (out_more),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Offers one input beat. Valid stays high afterwards so that the next beat
  // can follow without a bubble; this task lowers it only ahead of a gap.
  task automatic send_item(input logic restart);
    int gap;
    gap = burst ? 0 : gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // Config beat; the caller lowers valid after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sets both registers, restarts and steps a fixed number of times.
  task automatic enumerate_from(input logic [CFG_DATA_W-1:0] cnt,
                                input logic [CFG_DATA_W-1:0] tot, input int steps);
    wait_idle();
    write_reg(REG_PART_COUNT, cnt);
    write_reg(REG_TOTAL, tot);
    cfg_valid <= 1'b0;
    send_item(1'b1);
    repeat (steps) send_item(1'b0);
  endtask

  // Receiver: random stalls, with one long hold-off when the stimulus asks.
  initial begin : receiver
    int   hold;
    logic long_done;
    long_done = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold_req && !long_done) begin
        long_done = 1'b1;
        hold      = LONG_HOLD;
      end else begin
        hold = gap_cycles();
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 80)) @(posedge clk);
      else repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus: directed cases first, then random enumeration runs.
  initial begin : stimulus
    int                    items;
    int                    len;
    int                    r;
    int                    w;
    logic                  noisy;
    logic                  rs;
    logic                  first_phase;
    logic [CFG_DATA_W-1:0] cnt;
    logic [CFG_DATA_W-1:0] tot;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_restart    <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_PART_COUNT;
    cfg_data      <= '0;
    long_hold_req <= 1'b0;
    burst          = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: held split on the first advance, then the two-part
    // sequence of a zero total runs out and stays exhausted until a restart.
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);

    // Zero parts, one part, saturated part count with the largest total.
    enumerate_from(8'd0, 8'hFF, 2);
    enumerate_from(8'd1, 8'hFF, 1);
    enumerate_from(8'hFF, 8'hFF, 3);
    // Short sequences that run to exhaustion, including all parts zero.
    enumerate_from(8'd2, 8'd2, 3);
    enumerate_from(8'd3, 8'd1, 4);
    enumerate_from(8'd8, 8'd0, 1);

    // Random runs: mostly a restart followed by advances, with some noise.
    items       = 0;
    first_phase = 1'b1;
    while (items < RANDOM_ITEMS) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 65) begin
        cnt = CFG_DATA_W'($urandom_range(2, 5));
        tot = CFG_DATA_W'($urandom_range(0, 12));
      end else if (r < 80) begin
        cnt = CFG_DATA_W'($urandom_range(6, 8));
        tot = CFG_DATA_W'($urandom_range(0, 5));
      end else if (r < 85) begin
        cnt = CFG_DATA_W'($urandom_range(0, 1));
        tot = CFG_DATA_W'($urandom_range(0, 255));
      end else begin
        cnt = CFG_DATA_W'($urandom_range(0, 255));
        tot = CFG_DATA_W'($urandom_range(0, 255));
      end
      w = $urandom_range(0, 3);
      if (w != 1) write_reg(REG_PART_COUNT, cnt);
      if (w != 0) write_reg(REG_TOTAL, tot);
      cfg_valid <= 1'b0;

      noisy = ($urandom_range(0, 9) == 0);
      if (first_phase) begin
        // The receiver holds off while this run keeps the input busy.
        long_hold_req <= 1'b1;
        burst          = 1'b1;
        noisy          = 1'b0;
        len            = 60;
        first_phase    = 1'b0;
      end else begin
        burst = ($urandom_range(0, 3) == 0);
        len   = $urandom_range(1, 70);
      end

      for (int k = 0; k < len; k++) begin
        if (noisy) rs = 1'($urandom_range(0, 1));
        else if (k == 0) rs = ($urandom_range(0, 9) != 0);
        else rs = ($urandom_range(0, 49) == 0);
        send_item(rs);
      end
      items += len;
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ce_pkg.sv
design/ce_ctrl.sv
design/ce_dp.sv
design/composition_enumerator.sv
test/ce_checker.sv
test/tb_composition_enumerator.sv
